/* rtl/prime_count_in_range_macros.svh */
// Assertion macros used by the checker file of prime_count_in_range.
// Depends on nothing; the asserting scope must provide aclk and aresetn.
`ifndef PRIME_COUNT_IN_RANGE_MACROS_SVH
`define PRIME_COUNT_IN_RANGE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prime_count_in_range: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prime_count_in_range: next-cycle check failed");

`endif

/* rtl/pcr_pkg.sv */
// Shared types, constants and the microcode program of prime_count_in_range.
// Depends on nothing; used by the sequencer, the remainder unit, the top level and the checker.
package pcr_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 20;
    localparam int unsigned PC_W            = 4;
    localparam int unsigned COND_W          = 4;

    // Jump conditions
    localparam logic [COND_W-1:0] COND_NONE       = 4'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] COND_NO_IN      = 4'd2;
    localparam logic [COND_W-1:0] COND_CAND_GE_HI = 4'd3;
    localparam logic [COND_W-1:0] COND_CAND_LT2   = 4'd4;
    localparam logic [COND_W-1:0] COND_SQ_GT_CAND = 4'd5;
    localparam logic [COND_W-1:0] COND_REM_BUSY   = 4'd6;
    localparam logic [COND_W-1:0] COND_REM_ZERO   = 4'd7;
    localparam logic [COND_W-1:0] COND_NO_OUT     = 4'd8;

    // Program addresses
    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] STEP_RANGE  = 4'd1;
    localparam logic [PC_W-1:0] STEP_SMALL  = 4'd2;
    localparam logic [PC_W-1:0] STEP_INIT   = 4'd3;
    localparam logic [PC_W-1:0] STEP_TEST   = 4'd4;
    localparam logic [PC_W-1:0] STEP_START  = 4'd5;
    localparam logic [PC_W-1:0] STEP_WAIT   = 4'd6;
    localparam logic [PC_W-1:0] STEP_CHECK  = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIVINC = 4'd8;
    localparam logic [PC_W-1:0] STEP_PRIME  = 4'd9;
    localparam logic [PC_W-1:0] STEP_NEXT   = 4'd10;
    localparam logic [PC_W-1:0] STEP_DONE   = 4'd11;
    localparam logic [PC_W-1:0] STEP_WRAP   = 4'd12;

    typedef struct packed {
        logic              in_ready;
        logic              out_valid;
        logic              div_init;
        logic              rem_start;
        logic              div_step;
        logic              cnt_inc;
        logic              cand_inc;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } pcr_ctrl_t;

    typedef struct packed {
        logic s_valid;
        logic m_ready;
        logic cand_ge_hi;
        logic cand_lt2;
        logic sq_gt_cand;
        logic rem_busy;
        logic rem_zero;
    } pcr_flags_t;

    // Microcode store: one control word per step.
    function automatic pcr_ctrl_t pcr_rom(input logic [PC_W-1:0] addr);
        pcr_ctrl_t w;
        w = '0;
        case (addr)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = COND_NO_IN;
                w.target   = STEP_IDLE;
            end
            STEP_RANGE: begin
                w.cond   = COND_CAND_GE_HI;
                w.target = STEP_DONE;
            end
            STEP_SMALL: begin
                w.cond   = COND_CAND_LT2;
                w.target = STEP_NEXT;
            end
            STEP_INIT: begin
                w.div_init = 1'b1;
            end
            STEP_TEST: begin
                w.cond   = COND_SQ_GT_CAND;
                w.target = STEP_PRIME;
            end
            STEP_START: begin
                w.rem_start = 1'b1;
            end
            STEP_WAIT: begin
                w.cond   = COND_REM_BUSY;
                w.target = STEP_WAIT;
            end
            STEP_CHECK: begin
                w.cond   = COND_REM_ZERO;
                w.target = STEP_NEXT;
            end
            STEP_DIVINC: begin
                w.div_step = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_TEST;
            end
            STEP_PRIME: begin
                w.cnt_inc = 1'b1;
            end
            STEP_NEXT: begin
                w.cand_inc = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_RANGE;
            end
            STEP_DONE: begin
                w.out_valid = 1'b1;
                w.cond      = COND_NO_OUT;
                w.target    = STEP_DONE;
            end
            STEP_WRAP: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/pcr_seq.sv */
// Microcode sequencer: step counter, program store lookup and jump logic.
// Depends on pcr_pkg.
module pcr_seq
    import pcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pcr_flags_t flags,
    output pcr_ctrl_t  ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign ctrl = pcr_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_NONE:       jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_NO_IN:      jump = !flags.s_valid;
            COND_CAND_GE_HI: jump = flags.cand_ge_hi;
            COND_CAND_LT2:   jump = flags.cand_lt2;
            COND_SQ_GT_CAND: jump = flags.sq_gt_cand;
            COND_REM_BUSY:   jump = flags.rem_busy;
            COND_REM_ZERO:   jump = flags.rem_zero;
            COND_NO_OUT:     jump = !flags.m_ready;
            default:         jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/pcr_rem.sv */
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on pcr_pkg for the default width.
module pcr_rem
    import pcr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,   // held by the caller while busy
    output logic                   busy,
    output logic                   rem_zero
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign busy     = (cnt_reg != '0);
    assign rem_zero = (r_reg == '0);
    assign trial    = {r_reg, q_reg[VALUE_WIDTH-1]};
    assign diff     = trial - {1'b0, divisor};

    always_comb begin
        r_next   = r_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start) begin
            r_next   = '0;
            q_next   = dividend;
            cnt_next = CNT_W'(VALUE_WIDTH);
        end else if (busy) begin
            // subtract when the trial remainder covers the divisor
            r_next   = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            q_next   = {q_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        q_reg <= q_next;
    end

endmodule

/* rtl/prime_count_in_range.sv */
// Prime counter over a half-open range [s_lower_bound, s_upper_bound): each
// item returns one m_prime_count, the number of primes in the range (zero for
// an empty or reversed range; 0 and 1 are never counted). Work runs one item
// at a time under a microcoded sequencer driving trial division, each trial
// divisor going through a bit-serial remainder unit (divisors run from 2
// while divisor*divisor <= candidate, stopping at the first exact divisor).
// Per candidate the sequencer checks the range end and skips 0 and 1; then,
// for each divisor, it tests the square, starts the remainder unit, waits
// while the unit is busy, checks for a zero remainder and, if none, advances
// the divisor. A candidate with no exact divisor is counted. After the result
// item is taken the sequencer passes through STEP_WRAP before s_ready rises
// again. s_ready is high only while no item is in progress; the result is
// held on m_prime_count with m_valid until taken.
// Depends on pcr_pkg, pcr_seq and pcr_rem.
module prime_count_in_range
    import pcr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_lower_bound,
    input  logic [VALUE_WIDTH-1:0] s_upper_bound,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_prime_count
);

    localparam int unsigned SQ_W = VALUE_WIDTH + 2;

    pcr_ctrl_t  ctrl;
    pcr_flags_t flags;

    // Datapath registers (payload, no reset needed)
    logic [VALUE_WIDTH-1:0] cand_reg,  cand_next;
    logic [VALUE_WIDTH-1:0] hi_reg,    hi_next;
    logic [VALUE_WIDTH-1:0] div_reg,   div_next;
    logic [SQ_W-1:0]        sq_reg,    sq_next;
    logic [VALUE_WIDTH-1:0] count_reg, count_next;

    logic rem_busy;
    logic rem_zero;
    logic load;

    assign s_ready       = ctrl.in_ready;
    assign m_valid       = ctrl.out_valid;
    assign m_prime_count = count_reg;
    assign load          = ctrl.in_ready && s_valid;

    // Status seen by the sequencer's jump logic
    assign flags.s_valid    = s_valid;
    assign flags.m_ready    = m_ready;
    assign flags.cand_ge_hi = (cand_reg >= hi_reg);
    assign flags.cand_lt2   = (cand_reg[VALUE_WIDTH-1:1] == '0);
    assign flags.sq_gt_cand = (sq_reg > {2'b00, cand_reg});
    assign flags.rem_busy   = rem_busy;
    assign flags.rem_zero   = rem_zero;

    pcr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    pcr_rem #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.rem_start),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .busy     (rem_busy),
        .rem_zero (rem_zero)
    );

    always_comb begin
        cand_next  = cand_reg;
        hi_next    = hi_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        count_next = count_reg;
        // take a new range and clear the tally
        if (load) begin
            cand_next  = s_lower_bound;
            hi_next    = s_upper_bound;
            count_next = '0;
        end
        // restart trial division at divisor 2, square 4
        if (ctrl.div_init) begin
            div_next = VALUE_WIDTH'(2);
            sq_next  = SQ_W'(4);
        end
        // advance the divisor, keeping its square by (d+1)^2 = d^2 + 2d + 1
        if (ctrl.div_step) begin
            div_next = div_reg + VALUE_WIDTH'(1);
            sq_next  = sq_reg + {1'b0, div_reg, 1'b1};
        end
        if (ctrl.cnt_inc) begin
            count_next = count_reg + VALUE_WIDTH'(1);
        end
        // cand stays below hi here, so the step never wraps
        if (ctrl.cand_inc) begin
            cand_next = cand_reg + VALUE_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg  <= cand_next;
        hi_reg    <= hi_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
    end

endmodule

/* rtl/pcr_checker.sv */
// Port-level checker for prime_count_in_range, bound to the top level.
// Depends on pcr_pkg and prime_count_in_range_macros.svh.
`include "prime_count_in_range_macros.svh"

module pcr_checker
    import pcr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [VALUE_WIDTH-1:0] m_prime_count
);

    // hold a stalled result item
    `PCR_ASSERT_NEXT(a_out_valid_holds, m_valid && !m_ready, m_valid)
    `PCR_ASSERT_NEXT(a_out_data_holds, m_valid && !m_ready, $stable(m_prime_count))
    // one item at a time: no intake while a result is offered
    `PCR_ASSERT_IMPL(a_no_intake_with_result, m_valid, !s_ready)
    // an accepted range never yields its count on the next cycle
    `PCR_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready, !m_valid)
    // a taken result is not offered again
    `PCR_ASSERT_NEXT(a_no_repeat, m_valid && m_ready, !m_valid)

endmodule

bind prime_count_in_range pcr_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pcr_checker (.*);
